// ===== design/assert_macros.svh =====
// Assertion macros shared by the sector transfer RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside of reset.
`define SST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check on every clock edge, reset included.
`define SST_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== design/sst_pkg.sv =====
// Shared types, constants and helpers for the SD SPI sector transfer block.
// No dependencies.
`timescale 1ns / 1ps

package sst_pkg;

    // Block geometry
    localparam int unsigned BLOCK_BYTES = 512;
    localparam int unsigned IDX_W       = 10;

    // Register widths
    localparam int unsigned RESP_W = 16;
    localparam int unsigned BUSY_W = 20;
    localparam int unsigned CFG_W  = 20;

    // Configuration register indexes
    localparam logic [1:0] CFG_HIGH_CAPACITY  = 2'd0;
    localparam logic [1:0] CFG_RESPONSE_TRIES = 2'd1;
    localparam logic [1:0] CFG_TOKEN_TRIES    = 2'd2;
    localparam logic [1:0] CFG_BUSY_TRIES     = 2'd3;

    // Register reset values
    localparam logic [RESP_W-1:0] RESPONSE_TRIES_RST = 16'd300;
    localparam logic [RESP_W-1:0] TOKEN_TRIES_RST    = 16'd2000;
    localparam logic [BUSY_W-1:0] BUSY_TRIES_RST     = 20'd1000000;

    // Input modes
    localparam logic [1:0] MODE_CONTINUE = 2'd0;
    localparam logic [1:0] MODE_READ     = 2'd1;
    localparam logic [1:0] MODE_WRITE    = 2'd2;

    // Completion status codes
    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_NOT_READY     = 3'd1;
    localparam logic [2:0] ST_CMD_REJECTED  = 3'd2;
    localparam logic [2:0] ST_NO_TOKEN      = 3'd3;
    localparam logic [2:0] ST_DATA_REJECTED = 3'd4;
    localparam logic [2:0] ST_BUSY_TIMEOUT  = 3'd5;

    // Bus bytes
    localparam logic [7:0] BYTE_IDLE        = 8'hFF;
    localparam logic [7:0] BYTE_START_TOKEN = 8'hFE;
    localparam logic [7:0] CMD17_BYTE       = 8'h51;
    localparam logic [7:0] CMD24_BYTE       = 8'h58;
    localparam logic [7:0] CMD17_CRC        = 8'h01;
    localparam logic [7:0] DRESP_MASK       = 8'h0E;
    localparam logic [7:0] DRESP_ACCEPTED   = 8'h04;

    // Sequencer phases, one-hot
    typedef enum logic [12:0] {
        PH_IDLE  = 13'b0000000000001,
        PH_RDY0  = 13'b0000000000010,
        PH_CMD   = 13'b0000000000100,
        PH_R1    = 13'b0000000001000,
        PH_TOKEN = 13'b0000000010000,
        PH_RDATA = 13'b0000000100000,
        PH_RCRC  = 13'b0000001000000,
        PH_FINAL = 13'b0000010000000,
        PH_GAP   = 13'b0000100000000,
        PH_WDATA = 13'b0001000000000,
        PH_WCRC  = 13'b0010000000000,
        PH_WRESP = 13'b0100000000000,
        PH_BUSY  = 13'b1000000000000
    } t_phase;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] sector_address;
        logic [7:0]  miso_byte;
        logic [7:0]  write_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0] mosi_byte;
        logic       select_active;
        logic [7:0] read_data;
        logic       read_valid;
        logic       write_taken;
        logic       done_res;
        logic [2:0] status;
        logic [7:0] r1_response;
    } t_out_item;

    typedef struct packed {
        logic              high_capacity;
        logic [RESP_W-1:0] response_tries;
        logic [RESP_W-1:0] token_tries;
        logic [BUSY_W-1:0] busy_tries;
    } t_cfg;

    // Byte k of the six-byte command frame
    function automatic logic [7:0] frame_byte(input logic is_write,
                                              input logic [31:0] addr,
                                              input logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0:    b = is_write ? CMD24_BYTE : CMD17_BYTE;
            3'd1:    b = addr[31:24];
            3'd2:    b = addr[23:16];
            3'd3:    b = addr[15:8];
            3'd4:    b = addr[7:0];
            default: b = is_write ? BYTE_IDLE : CMD17_CRC;
        endcase
        return b;
    endfunction

endpackage

// ===== design/sst_cfg_regs.sv =====
// Configuration register file for the sector transfer block.
// Depends on sst_pkg.
`timescale 1ns / 1ps

module sst_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [sst_pkg::CFG_W-1:0]  i_cfg_data,
    output sst_pkg::t_cfg              o_cfg
);

    sst_pkg::t_cfg r_cfg;

    // Register writes, decoded by index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_capacity  <= 1'b0;
            r_cfg.response_tries <= sst_pkg::RESPONSE_TRIES_RST;
            r_cfg.token_tries    <= sst_pkg::TOKEN_TRIES_RST;
            r_cfg.busy_tries     <= sst_pkg::BUSY_TRIES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sst_pkg::CFG_HIGH_CAPACITY:  r_cfg.high_capacity  <= i_cfg_data[0];
                sst_pkg::CFG_RESPONSE_TRIES: r_cfg.response_tries <=
                                                 i_cfg_data[sst_pkg::RESP_W-1:0];
                sst_pkg::CFG_TOKEN_TRIES:    r_cfg.token_tries    <=
                                                 i_cfg_data[sst_pkg::RESP_W-1:0];
                sst_pkg::CFG_BUSY_TRIES:     r_cfg.busy_tries     <=
                                                 i_cfg_data[sst_pkg::BUSY_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/sst_step.sv =====
// Transfer sequencer: phase state and the per-slot decision logic.
// Depends on sst_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sst_step (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  sst_pkg::t_in_item     i_item,
    input  sst_pkg::t_cfg         i_cfg,
    output sst_pkg::t_out_item    o_result
);

    sst_pkg::t_phase                r_phase, n_phase;
    logic                           r_is_write, n_is_write;
    logic [sst_pkg::IDX_W-1:0]      r_byte_index, n_byte_index;
    logic [sst_pkg::BUSY_W-1:0]     r_tries_left, n_tries_left;
    logic [31:0]                    r_card_address, n_card_address;
    logic [7:0]                     r_last_r1, n_last_r1;
    logic [2:0]                     r_result_code, n_result_code;

    logic                           w_spent;
    logic [sst_pkg::BUSY_W-1:0]     w_tries_dec;
    logic [sst_pkg::IDX_W:0]        w_idx_inc;
    logic                           w_done;
    logic [7:0]                     w_miso;

    // One try of a bounded wait
    assign w_spent     = (r_tries_left <= sst_pkg::BUSY_W'(1));
    assign w_tries_dec = w_spent ? '0 : r_tries_left - sst_pkg::BUSY_W'(1);
    assign w_idx_inc   = {1'b0, r_byte_index} + (sst_pkg::IDX_W+1)'(1);
    assign w_miso      = i_item.miso_byte;

    // Next state and result for the current byte slot
    always_comb begin
        n_phase        = r_phase;
        n_is_write     = r_is_write;
        n_byte_index   = r_byte_index;
        n_tries_left   = r_tries_left;
        n_card_address = r_card_address;
        n_last_r1      = r_last_r1;
        n_result_code  = r_result_code;
        w_done         = 1'b0;
        o_result       = '0;
        o_result.mosi_byte     = sst_pkg::BYTE_IDLE;
        o_result.select_active = 1'b1;

        case (r_phase)
            sst_pkg::PH_IDLE: begin
                if (i_item.mode inside {sst_pkg::MODE_READ, sst_pkg::MODE_WRITE}) begin
                    n_is_write     = (i_item.mode == sst_pkg::MODE_WRITE);
                    n_card_address = i_cfg.high_capacity ? i_item.sector_address
                                                         : {i_item.sector_address[22:0], 9'd0};
                    n_result_code  = sst_pkg::ST_OK;
                    n_last_r1      = sst_pkg::BYTE_IDLE;
                    n_byte_index   = '0;
                    n_tries_left   = sst_pkg::BUSY_W'(i_cfg.response_tries);
                    n_phase        = sst_pkg::PH_RDY0;
                end else begin
                    o_result.select_active = 1'b0;
                end
            end
            sst_pkg::PH_RDY0: begin
                // not ready after all tries is recorded, command still goes out
                if (w_miso != sst_pkg::BYTE_IDLE) begin
                    n_tries_left = w_tries_dec;
                end
                if (w_miso == sst_pkg::BYTE_IDLE || w_spent) begin
                    if (w_miso != sst_pkg::BYTE_IDLE && r_result_code == sst_pkg::ST_OK) begin
                        n_result_code = sst_pkg::ST_NOT_READY;
                    end
                    o_result.mosi_byte = sst_pkg::frame_byte(r_is_write, r_card_address, 3'd0);
                    n_byte_index       = sst_pkg::IDX_W'(1);
                    n_phase            = sst_pkg::PH_CMD;
                end
            end
            sst_pkg::PH_CMD: begin
                if (r_byte_index < sst_pkg::IDX_W'(6)) begin
                    o_result.mosi_byte = sst_pkg::frame_byte(r_is_write, r_card_address,
                                                             r_byte_index[2:0]);
                    n_byte_index       = w_idx_inc[sst_pkg::IDX_W-1:0];
                end else begin
                    n_tries_left = sst_pkg::BUSY_W'(i_cfg.response_tries);
                    n_phase      = sst_pkg::PH_R1;
                end
            end
            sst_pkg::PH_R1: begin
                n_last_r1 = w_miso;
                if (w_miso == 8'h00) begin
                    if (r_is_write) begin
                        n_byte_index = sst_pkg::IDX_W'(1);
                        n_phase      = sst_pkg::PH_GAP;
                    end else begin
                        n_tries_left = sst_pkg::BUSY_W'(i_cfg.token_tries);
                        n_phase      = sst_pkg::PH_TOKEN;
                    end
                end else begin
                    // bit 7 set means no response yet
                    if (w_miso[7]) begin
                        n_tries_left = w_tries_dec;
                    end
                    if (!w_miso[7] || w_spent) begin
                        if (r_result_code == sst_pkg::ST_OK) begin
                            n_result_code = sst_pkg::ST_CMD_REJECTED;
                        end
                        if (r_is_write) begin
                            w_done = 1'b1;
                        end else begin
                            n_tries_left = sst_pkg::BUSY_W'(i_cfg.response_tries);
                            n_phase      = sst_pkg::PH_FINAL;
                        end
                    end
                end
            end
            sst_pkg::PH_TOKEN: begin
                if (w_miso == sst_pkg::BYTE_START_TOKEN) begin
                    n_byte_index = '0;
                    n_phase      = sst_pkg::PH_RDATA;
                end else begin
                    if (w_miso == sst_pkg::BYTE_IDLE) begin
                        n_tries_left = w_tries_dec;
                    end
                    // error token ends the wait at once
                    if (w_miso != sst_pkg::BYTE_IDLE || w_spent) begin
                        if (r_result_code == sst_pkg::ST_OK) begin
                            n_result_code = sst_pkg::ST_NO_TOKEN;
                        end
                        n_tries_left = sst_pkg::BUSY_W'(i_cfg.response_tries);
                        n_phase      = sst_pkg::PH_FINAL;
                    end
                end
            end
            sst_pkg::PH_RDATA: begin
                o_result.read_valid = 1'b1;
                o_result.read_data  = w_miso;
                if (w_idx_inc >= (sst_pkg::IDX_W+1)'(sst_pkg::BLOCK_BYTES)) begin
                    n_byte_index = '0;
                    n_phase      = sst_pkg::PH_RCRC;
                end else begin
                    n_byte_index = w_idx_inc[sst_pkg::IDX_W-1:0];
                end
            end
            sst_pkg::PH_RCRC: begin
                // two CRC bytes are dropped
                if (r_byte_index == '0) begin
                    n_byte_index = sst_pkg::IDX_W'(1);
                end else begin
                    n_tries_left = sst_pkg::BUSY_W'(i_cfg.response_tries);
                    n_phase      = sst_pkg::PH_FINAL;
                end
            end
            sst_pkg::PH_FINAL: begin
                if (w_miso == sst_pkg::BYTE_IDLE) begin
                    w_done = 1'b1;
                end else begin
                    n_tries_left = w_tries_dec;
                    if (w_spent) begin
                        if (r_result_code == sst_pkg::ST_OK) begin
                            n_result_code = sst_pkg::ST_NOT_READY;
                        end
                        w_done = 1'b1;
                    end
                end
            end
            sst_pkg::PH_GAP: begin
                if (r_byte_index < sst_pkg::IDX_W'(3)) begin
                    n_byte_index = w_idx_inc[sst_pkg::IDX_W-1:0];
                end else begin
                    o_result.mosi_byte = sst_pkg::BYTE_START_TOKEN;
                    n_byte_index       = '0;
                    n_phase            = sst_pkg::PH_WDATA;
                end
            end
            sst_pkg::PH_WDATA: begin
                o_result.mosi_byte   = i_item.write_data;
                o_result.write_taken = 1'b1;
                if (w_idx_inc >= (sst_pkg::IDX_W+1)'(sst_pkg::BLOCK_BYTES)) begin
                    n_byte_index = '0;
                    n_phase      = sst_pkg::PH_WCRC;
                end else begin
                    n_byte_index = w_idx_inc[sst_pkg::IDX_W-1:0];
                end
            end
            sst_pkg::PH_WCRC: begin
                if (r_byte_index < sst_pkg::IDX_W'(2)) begin
                    n_byte_index = w_idx_inc[sst_pkg::IDX_W-1:0];
                end else begin
                    n_phase = sst_pkg::PH_WRESP;
                end
            end
            sst_pkg::PH_WRESP: begin
                if ((w_miso & sst_pkg::DRESP_MASK) == sst_pkg::DRESP_ACCEPTED) begin
                    n_tries_left = i_cfg.busy_tries;
                    n_phase      = sst_pkg::PH_BUSY;
                end else begin
                    if (r_result_code == sst_pkg::ST_OK) begin
                        n_result_code = sst_pkg::ST_DATA_REJECTED;
                    end
                    w_done = 1'b1;
                end
            end
            sst_pkg::PH_BUSY: begin
                if (w_miso == sst_pkg::BYTE_IDLE) begin
                    w_done = 1'b1;
                end else begin
                    n_tries_left = w_tries_dec;
                    if (w_spent) begin
                        if (r_result_code == sst_pkg::ST_OK) begin
                            n_result_code = sst_pkg::ST_BUSY_TIMEOUT;
                        end
                        w_done = 1'b1;
                    end
                end
            end
            default: begin
                n_phase                = sst_pkg::PH_IDLE;
                o_result.select_active = 1'b0;
            end
        endcase

        // ending slot releases chip select
        if (w_done) begin
            o_result.mosi_byte     = sst_pkg::BYTE_IDLE;
            o_result.select_active = 1'b0;
            n_phase                = sst_pkg::PH_IDLE;
            n_byte_index           = '0;
        end

        o_result.done_res    = w_done;
        o_result.status      = w_done ? n_result_code : sst_pkg::ST_OK;
        o_result.r1_response = n_last_r1;
    end

    // State update on each transferred slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= sst_pkg::PH_IDLE;
            r_is_write     <= 1'b0;
            r_byte_index   <= '0;
            r_tries_left   <= '0;
            r_card_address <= '0;
            r_last_r1      <= sst_pkg::BYTE_IDLE;
            r_result_code  <= sst_pkg::ST_OK;
        end else if (i_fire) begin
            r_phase        <= n_phase;
            r_is_write     <= n_is_write;
            r_byte_index   <= n_byte_index;
            r_tries_left   <= n_tries_left;
            r_card_address <= n_card_address;
            r_last_r1      <= n_last_r1;
            r_result_code  <= n_result_code;
        end
    end

    // Checks
    `SST_ASSERT(a_done_to_idle, i_fire && w_done |=> r_phase == sst_pkg::PH_IDLE, "done slot did not return to idle")
    `SST_ASSERT(a_status_only_on_done, !w_done |-> o_result.status == sst_pkg::ST_OK, "status set outside done slot")
    `SST_ASSERT(a_read_write_excl, !(o_result.read_valid && o_result.write_taken), "read and write data in one slot")
    `SST_ASSERT(a_index_bound, r_byte_index < sst_pkg::IDX_W'(sst_pkg::BLOCK_BYTES), "byte index past block end")

endmodule

// ===== design/sd_spi_sector_transfer.sv =====
// An item transferred in passes the input register, then the result register, where
// its result appears; throughput is one item per cycle unless the output stalls.
// The sequencer state advances once per item, so items may follow back to back.
// Reset (i_rst_n low at a clock edge, synchronous) empties both registers,
// returns the sequencer to idle and loads the default register values.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sd_spi_sector_transfer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  sst_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output sst_pkg::t_out_item         o_out_data,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [sst_pkg::CFG_W-1:0]  i_cfg_data
);

    logic                  r_in_valid;
    sst_pkg::t_in_item     r_in_item;
    logic                  r_out_valid;
    sst_pkg::t_out_item    r_out_item;
    logic                  w_advance;
    sst_pkg::t_cfg         w_cfg;
    sst_pkg::t_out_item    w_result;

    sst_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    sst_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_advance),
        .i_item   (r_in_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // Item moves to the result register when that slot is free
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    // Checks
    `SST_ASSERT(a_in_hold, r_in_valid && !w_advance |=> r_in_valid && $stable(r_in_item), "held item lost")
    `SST_ASSERT(a_out_hold, r_out_valid && !i_out_ready |=> r_out_valid, "stalled result dropped")
    `SST_ASSERT(a_advance_fills, w_advance |=> r_out_valid, "advanced item missing at output")

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for the SD SPI-mode single-block sequencer: byte slots go in over valid/ready,
// a scoreboard class predicts each slot's result and checks it field by field.
// Depends on sst_pkg and the sd_spi_sector_transfer top level.
`timescale 1ns / 1ps

module testbench;
    import sst_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    // longest wait that is allowed to run into its timeout
    localparam int unsigned STUB_MAX = 2100;

    // Predicts the sequencer slot by slot and holds the expected results in order
    class transfer_scoreboard;
        // register copies
        logic              high_cap;
        logic [RESP_W-1:0] resp_tries;
        logic [RESP_W-1:0] tok_tries;
        logic [BUSY_W-1:0] busy_lim;
        // sequencer copy
        t_phase            seq_phase;
        logic              is_wr;
        int unsigned       idx;
        logic [BUSY_W-1:0] tries_left;
        logic [31:0]       card_addr;
        logic [7:0]        last_r1;
        logic [2:0]        fail_code;
        t_out_item         slot_q[$];
        int unsigned       fails;

        function new();
            high_cap   = 1'b0;
            resp_tries = RESPONSE_TRIES_RST;
            tok_tries  = TOKEN_TRIES_RST;
            busy_lim   = BUSY_TRIES_RST;
            seq_phase  = PH_IDLE;
            is_wr      = 1'b0;
            idx        = 0;
            tries_left = '0;
            card_addr  = '0;
            last_r1    = BYTE_IDLE;
            fail_code  = ST_OK;
            fails      = 0;
        endfunction

        function void set_reg(logic [1:0] sel, logic [CFG_W-1:0] val);
            case (sel)
                CFG_HIGH_CAPACITY:  high_cap   = val[0];
                CFG_RESPONSE_TRIES: resp_tries = val[RESP_W-1:0];
                CFG_TOKEN_TRIES:    tok_tries  = val[RESP_W-1:0];
                CFG_BUSY_TRIES:     busy_lim   = val[BUSY_W-1:0];
                default: ;
            endcase
        endfunction

        // status keeps the first failure of the transfer
        function void flag_fail(logic [2:0] code);
            if (fail_code == ST_OK) fail_code = code;
        endfunction

        // one slot of a bounded wait; 1 when the wait is used up
        function bit take_try();
            if (tries_left <= 20'd1) begin
                tries_left = '0;
                return 1'b1;
            end
            tries_left = tries_left - 20'd1;
            return 1'b0;
        endfunction

        function logic [7:0] cmd_frame(int unsigned k);
            case (k)
                0:       return is_wr ? CMD24_BYTE : CMD17_BYTE;
                1:       return card_addr[31:24];
                2:       return card_addr[23:16];
                3:       return card_addr[15:8];
                4:       return card_addr[7:0];
                default: return is_wr ? BYTE_IDLE : CMD17_CRC;
            endcase
        endfunction

        function t_out_item predict_slot(t_in_item it);
            t_out_item r;
            logic      fin;
            logic      dn;
            r.mosi_byte     = BYTE_IDLE;
            r.select_active = 1'b1;
            r.read_data     = 8'h00;
            r.read_valid    = 1'b0;
            r.write_taken   = 1'b0;
            dn = 1'b0;
            case (seq_phase)
                PH_IDLE: begin
                    if (it.mode inside {MODE_READ, MODE_WRITE}) begin
                        is_wr      = (it.mode == MODE_WRITE);
                        card_addr  = high_cap ? it.sector_address
                                              : {it.sector_address[22:0], 9'd0};
                        fail_code  = ST_OK;
                        last_r1    = BYTE_IDLE;
                        idx        = 0;
                        tries_left = {4'd0, resp_tries};
                        seq_phase  = PH_RDY0;
                    end else begin
                        r.select_active = 1'b0;
                    end
                end
                PH_RDY0: begin
                    fin = (it.miso_byte == BYTE_IDLE) ? 1'b1 : take_try();
                    if (fin) begin
                        // command goes out even when the card never got ready
                        if (it.miso_byte != BYTE_IDLE) flag_fail(ST_NOT_READY);
                        r.mosi_byte = cmd_frame(0);
                        idx = 1;
                        seq_phase = PH_CMD;
                    end
                end
                PH_CMD: begin
                    if (idx < 6) begin
                        r.mosi_byte = cmd_frame(idx);
                        idx++;
                    end else begin
                        tries_left = {4'd0, resp_tries};
                        seq_phase = PH_R1;
                    end
                end
                PH_R1: begin
                    last_r1 = it.miso_byte;
                    if (it.miso_byte == 8'h00) begin
                        if (is_wr) begin
                            idx = 1;
                            seq_phase = PH_GAP;
                        end else begin
                            tries_left = {4'd0, tok_tries};
                            seq_phase = PH_TOKEN;
                        end
                    end else begin
                        // nonzero R1 with bit 7 clear rejects at once, 0x80 set keeps polling
                        fin = !it.miso_byte[7] ? 1'b1 : take_try();
                        if (fin) begin
                            flag_fail(ST_CMD_REJECTED);
                            if (is_wr) begin
                                dn = 1'b1;
                            end else begin
                                tries_left = {4'd0, resp_tries};
                                seq_phase = PH_FINAL;
                            end
                        end
                    end
                end
                PH_TOKEN: begin
                    if (it.miso_byte == BYTE_START_TOKEN) begin
                        idx = 0;
                        seq_phase = PH_RDATA;
                    end else begin
                        fin = (it.miso_byte != BYTE_IDLE) ? 1'b1 : take_try();
                        if (fin) begin
                            flag_fail(ST_NO_TOKEN);
                            tries_left = {4'd0, resp_tries};
                            seq_phase = PH_FINAL;
                        end
                    end
                end
                PH_RDATA: begin
                    r.read_valid = 1'b1;
                    r.read_data  = it.miso_byte;
                    idx++;
                    if (idx >= BLOCK_BYTES) begin
                        idx = 0;
                        seq_phase = PH_RCRC;
                    end
                end
                PH_RCRC: begin
                    if (idx == 0) begin
                        idx = 1;
                    end else begin
                        tries_left = {4'd0, resp_tries};
                        seq_phase = PH_FINAL;
                    end
                end
                PH_FINAL: begin
                    if (it.miso_byte == BYTE_IDLE) begin
                        dn = 1'b1;
                    end else if (take_try()) begin
                        flag_fail(ST_NOT_READY);
                        dn = 1'b1;
                    end
                end
                PH_GAP: begin
                    if (idx < 3) begin
                        idx++;
                    end else begin
                        r.mosi_byte = BYTE_START_TOKEN;
                        idx = 0;
                        seq_phase = PH_WDATA;
                    end
                end
                PH_WDATA: begin
                    r.mosi_byte   = it.write_data;
                    r.write_taken = 1'b1;
                    idx++;
                    if (idx >= BLOCK_BYTES) begin
                        idx = 0;
                        seq_phase = PH_WCRC;
                    end
                end
                PH_WCRC: begin
                    if (idx < 2) idx++;
                    else seq_phase = PH_WRESP;
                end
                PH_WRESP: begin
                    if ((it.miso_byte & DRESP_MASK) == DRESP_ACCEPTED) begin
                        tries_left = busy_lim;
                        seq_phase = PH_BUSY;
                    end else begin
                        flag_fail(ST_DATA_REJECTED);
                        dn = 1'b1;
                    end
                end
                PH_BUSY: begin
                    if (it.miso_byte == BYTE_IDLE) begin
                        dn = 1'b1;
                    end else if (take_try()) begin
                        flag_fail(ST_BUSY_TIMEOUT);
                        dn = 1'b1;
                    end
                end
                default: begin
                    seq_phase = PH_IDLE;
                    r.select_active = 1'b0;
                end
            endcase
            // ending slot releases chip select and sends a dummy byte
            if (dn) begin
                r.mosi_byte     = BYTE_IDLE;
                r.select_active = 1'b0;
                seq_phase       = PH_IDLE;
                idx             = 0;
            end
            r.done_res    = dn;
            r.status      = dn ? fail_code : ST_OK;
            r.r1_response = last_r1;
            return r;
        endfunction

        function void note_slot(t_in_item it);
            slot_q.push_back(predict_slot(it));
        endfunction

        function void cmp(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                fails++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (slot_q.size() == 0) begin
                $error("result transfer with no slot waiting for it");
                fails++;
                return;
            end
            e = slot_q.pop_front();
            cmp("mosi_byte", e.mosi_byte, got.mosi_byte);
            cmp("select_active", 8'(e.select_active), 8'(got.select_active));
            cmp("read_data", e.read_data, got.read_data);
            cmp("read_valid", 8'(e.read_valid), 8'(got.read_valid));
            cmp("write_taken", 8'(e.write_taken), 8'(got.write_taken));
            cmp("done_res", 8'(e.done_res), 8'(got.done_res));
            cmp("status", 8'(e.status), 8'(got.status));
            cmp("r1_response", e.r1_response, got.r1_response);
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               o_in_ready;
    t_in_item           in_data;
    logic               o_out_valid;
    logic               out_ready = 1'b0;
    t_out_item          out_data;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    transfer_scoreboard sb;
    bit                 rx_long_req = 1'b0;
    int unsigned        tx_steady = 0;

    sd_spi_sector_transfer u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // hard stop
    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    // result receiver: short and long stalls, steady stretches, one long hold on request
    initial begin
        int unsigned hold;
        int unsigned steady;
        int unsigned r;
        hold = 0;
        steady = 0;
        forever begin
            @(negedge clk);
            if (rx_long_req) begin
                rx_long_req = 1'b0;
                hold = 400;
                steady = 0;
            end
            if (hold > 0) begin
                out_ready <= 1'b0;
                hold--;
            end else if (steady > 0) begin
                out_ready <= 1'b1;
                steady--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    steady = $urandom_range(30, 120);
                    out_ready <= 1'b1;
                end else if (r < 65) begin
                    out_ready <= 1'b1;
                end else if (r < 93) begin
                    hold = $urandom_range(0, 2);
                    out_ready <= 1'b0;
                end else begin
                    hold = $urandom_range(9, 50);
                    out_ready <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready) sb.check_result(out_data);
    end

    // offer one slot after a random gap and hold it until the transfer
    task automatic send_slot(t_in_item it);
        int unsigned gap;
        int unsigned r;
        gap = 0;
        if (tx_steady > 0) begin
            tx_steady--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 4) tx_steady = $urandom_range(30, 120);
            else if (r < 35) gap = $urandom_range(1, 3);
            else if (r < 40) gap = $urandom_range(8, 40);
        end
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
        sb.note_slot(it);
    endtask

    task automatic put(logic [1:0] m, logic [31:0] a, logic [7:0] b);
        t_in_item it;
        it.mode           = m;
        it.sector_address = a;
        it.miso_byte      = b;
        it.write_data     = 8'($urandom);
        send_slot(it);
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.slot_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(logic [1:0] sel, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(sel, val);
    endtask

    task automatic config_all(logic hc, logic [RESP_W-1:0] resp, logic [RESP_W-1:0] tok,
                              logic [BUSY_W-1:0] busy);
        write_cfg(CFG_HIGH_CAPACITY, {19'd0, hc});
        write_cfg(CFG_RESPONSE_TRIES, {4'd0, resp});
        write_cfg(CFG_TOKEN_TRIES, {4'd0, tok});
        write_cfg(CFG_BUSY_TRIES, busy);
    endtask

    // Random transfers: a card that answers each wait per a per-transfer plan
    // (quick, slow, stuck until timeout, or error byte), with noise modes mixed in.
    task automatic run_random(int unsigned target, bit clean_first, logic [1:0] first_mode,
                              int unsigned hold_at, int unsigned drain_at);
        int unsigned n;
        int unsigned r;
        bit          first;
        bit          clean;
        bit          nr;
        bit          quick;
        bit          stub_rdy0, stub_r1, stub_tok, stub_final, stub_busy;
        bit          err_r1, err_tok, err_wresp;
        logic [1:0]  m;
        logic [2:0]  rr;
        logic [7:0]  b;
        t_in_item    it;
        n = 0;
        first = 1'b1;
        quick = 1'b1;
        {stub_rdy0, stub_r1, stub_tok, stub_final, stub_busy} = '0;
        {err_r1, err_tok, err_wresp} = '0;
        while (n < target || sb.seq_phase != PH_IDLE) begin
            m = MODE_CONTINUE;
            if (sb.seq_phase == PH_IDLE) begin
                r = $urandom_range(0, 19);
                if (first && clean_first) m = first_mode;
                else if (r == 0) m = MODE_CONTINUE;
                else if (r == 1) m = MODE_UNUSED;
                else if (r <= 10) m = MODE_READ;
                else m = MODE_WRITE;
                if (m inside {MODE_READ, MODE_WRITE}) begin
                    clean = first && clean_first;
                    first = 1'b0;
                    quick = clean || ($urandom_range(0, 3) == 0);
                    stub_rdy0  = !clean && ($urandom_range(0, 9) == 0)
                                 && (32'(sb.resp_tries) <= STUB_MAX);
                    stub_r1    = !clean && ($urandom_range(0, 9) == 0)
                                 && (32'(sb.resp_tries) <= STUB_MAX);
                    stub_tok   = !clean && ($urandom_range(0, 9) == 0)
                                 && (32'(sb.tok_tries) <= STUB_MAX);
                    stub_final = !clean && ($urandom_range(0, 9) == 0)
                                 && (32'(sb.resp_tries) <= STUB_MAX);
                    stub_busy  = !clean && ($urandom_range(0, 9) == 0)
                                 && (32'(sb.busy_lim) <= STUB_MAX);
                    err_r1     = !clean && ($urandom_range(0, 7) == 0);
                    err_tok    = !clean && ($urandom_range(0, 7) == 0);
                    err_wresp  = !clean && ($urandom_range(0, 7) == 0);
                end
            end

            r = $urandom_range(0, 9);
            if (r == 0) it.sector_address = 32'h0;
            else if (r == 1) it.sector_address = 32'hFFFF_FFFF;
            else it.sector_address = $urandom;
            it.write_data = 8'($urandom);
            it.miso_byte  = 8'($urandom);
            it.mode       = m;
            // start codes in mid-transfer must be ignored
            if (sb.seq_phase != PH_IDLE)
                it.mode = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3))
                                                      : MODE_CONTINUE;

            nr = !quick && ($urandom_range(0, 2) == 0);
            case (sb.seq_phase)
                PH_RDY0: begin
                    if (stub_rdy0 || nr) it.miso_byte = 8'($urandom_range(0, 254));
                    else it.miso_byte = BYTE_IDLE;
                end
                PH_R1: begin
                    if (err_r1) it.miso_byte = 8'($urandom_range(1, 127));
                    else if (stub_r1 || nr) it.miso_byte = 8'h80 | 8'($urandom);
                    else it.miso_byte = 8'h00;
                end
                PH_TOKEN: begin
                    if (err_tok) it.miso_byte = 8'($urandom_range(0, 253));
                    else if (stub_tok || nr) it.miso_byte = BYTE_IDLE;
                    else it.miso_byte = BYTE_START_TOKEN;
                end
                PH_FINAL: begin
                    if (stub_final || nr) it.miso_byte = 8'($urandom_range(0, 254));
                    else it.miso_byte = BYTE_IDLE;
                end
                PH_WRESP: begin
                    b = 8'($urandom);
                    if (err_wresp) begin
                        // any status field except accepted
                        rr = 3'($urandom_range(0, 6));
                        if (rr >= 3'd2) rr = rr + 3'd1;
                        it.miso_byte = {b[7:4], rr, b[0]};
                    end else begin
                        it.miso_byte = {b[7:4], 3'b010, b[0]};
                    end
                end
                PH_BUSY: begin
                    if (stub_busy || nr)
                        it.miso_byte = $urandom_range(0, 1) ? 8'h00
                                                            : 8'($urandom_range(0, 254));
                    else
                        it.miso_byte = BYTE_IDLE;
                end
                default: ;
            endcase

            send_slot(it);
            n++;
            if (n == hold_at) begin
                rx_long_req = 1'b1;
                tx_steady = 500;
            end
            if (n == drain_at) settle();
        end
    endtask

    initial begin
        sb = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_HIGH_CAPACITY;
        cfg_data  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: block addressing, zero tries behave as one
        config_all(1'b1, 16'd0, 16'd0, 20'd1);
        // ignored codes while idle
        put(MODE_UNUSED, $urandom, 8'($urandom));
        put(MODE_CONTINUE, $urandom, 8'($urandom));
        // read: R1 rejected, final ready wait times out, first failure kept
        put(MODE_READ, 32'hFFFF_FFFF, 8'($urandom));
        put(MODE_CONTINUE, $urandom, BYTE_IDLE);
        repeat (6) put(2'($urandom_range(0, 3)), $urandom, 8'($urandom));
        put(MODE_CONTINUE, $urandom, 8'h04);
        put(MODE_CONTINUE, $urandom, 8'h00);
        // write: card not ready at start but command still sent, then R1 poll times out
        put(MODE_WRITE, 32'h0, 8'($urandom));
        put(MODE_CONTINUE, $urandom, 8'h00);
        repeat (6) put(2'($urandom_range(0, 3)), $urandom, 8'($urandom));
        put(MODE_CONTINUE, $urandom, 8'h80);
        // read: error token in place of the start token
        put(MODE_READ, $urandom, 8'($urandom));
        put(MODE_CONTINUE, $urandom, BYTE_IDLE);
        repeat (6) put(2'($urandom_range(0, 3)), $urandom, 8'($urandom));
        put(MODE_CONTINUE, $urandom, 8'h00);
        put(MODE_CONTINUE, $urandom, 8'h5A);
        put(MODE_CONTINUE, $urandom, BYTE_IDLE);
        settle();

        // default settings, one clean full read, long receiver hold
        config_all(1'b0, RESPONSE_TRIES_RST, TOKEN_TRIES_RST, BUSY_TRIES_RST);
        run_random(300, 1'b1, MODE_READ, 150, 0);
        settle();

        // tiny counts: timeouts everywhere, sender drains mid-run
        config_all(1'b1, 16'd2, 16'd1, 20'd0);
        run_random(220, 1'b0, MODE_CONTINUE, 0, 100);
        settle();

        if (sb.fails == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/sst_pkg.sv
design/sst_cfg_regs.sv
design/sst_step.sv
design/sd_spi_sector_transfer.sv
tb/sv/testbench.sv
